[src/table_driven_3d_curve_generator_unit_defines.svh]
// Assertion macros for the curve generator RTL.
`ifndef TABLE_DRIVEN_3D_CURVE_GENERATOR_UNIT_DEFINES_SVH
`define TABLE_DRIVEN_3D_CURVE_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[src/tdc_pkg.sv]
// Shared constants, types and helpers of the curve generator.
package tdc_pkg;
  localparam int MaxLevel = 4;
  localparam int AddrW = 3 * MaxLevel;
  localparam int Depth = 1 << AddrW;
  localparam int CoordW = 14;
  localparam int CntW = 13;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_LEVEL = 2'd1;
  localparam logic [1:0] ST_ROT = 2'd2;
  localparam logic [1:0] ST_INDEX = 2'd3;

  localparam logic [1:0] REG_STEP = 2'd0;
  localparam logic [1:0] REG_ROT_LO = 2'd1;
  localparam logic [1:0] REG_ROT_HI = 2'd2;
  localparam logic [1:0] REG_REV = 2'd3;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic       seed;
    logic [1:0] phase;
    logic [2:0] child;
    logic [AddrW-1:0] j;
    logic [AddrW-1:0] len_mask;
    logic       last_j;
    logic       first_j;
    logic       in_bank;
  } dp_cmd_t;

  function automatic logic [8:0] rot_of(input logic [71:0] rots, input logic [2:0] c);
    logic [8:0] r;
    r = rots[9*c +: 9];
    return r;
  endfunction

  function automatic logic rot_ok(input logic [8:0] r);
    logic [2:0] seen;
    logic ok;
    seen = '0;
    ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      unique case (r[3*k +: 3])
        3'd1, 3'd7: seen[0] = 1'b1;
        3'd2, 3'd6: seen[1] = 1'b1;
        3'd3, 3'd5: seen[2] = 1'b1;
        default: ok = 1'b0;
      endcase
    end
    return ok && (seen == 3'b111);
  endfunction

  // apply one child's signed permutation to a point
  function automatic logic [3*CoordW-1:0] rotate(input logic [8:0] r,
                                                 input logic [3*CoordW-1:0] p);
    logic [3*CoordW-1:0] o;
    coord_t v;
    o = '0;
    for (int k = 0; k < 3; k++) begin
      v = r[3*k+2] ? -p[CoordW*k +: CoordW] : p[CoordW*k +: CoordW];
      unique case (r[3*k +: 3])
        3'd2, 3'd6: o[CoordW*1 +: CoordW] = v;
        3'd3, 3'd5: o[CoordW*2 +: CoordW] = v;
        default: o[CoordW*0 +: CoordW] = v;
      endcase
    end
    return o;
  endfunction
endpackage

[src/tdc_if.sv]
// Valid/ready channel interfaces for the curve generator.
interface tdc_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [2:0] level;
  logic [11:0] index;
  modport source (output valid, op, level, index, input ready);
  modport sink (input valid, op, level, index, output ready);
endinterface

interface tdc_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [12:0] point_count;
  logic [11:0] coord_x;
  logic [11:0] coord_y;
  logic [11:0] coord_z;
  logic [20:0] linear_index;
  modport source (output valid, status, point_count, coord_x, coord_y, coord_z,
                  linear_index, input ready);
  modport sink (input valid, status, point_count, coord_x, coord_y, coord_z,
                linear_index, output ready);
endinterface

interface tdc_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [35:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/tdc_datapath.sv]
// Path memories, rotation/translation, minimum tracking and read output math.
module tdc_datapath (
  input  logic clk,
  input  tdc_pkg::dp_cmd_t cmd,
  input  logic [71:0] rots,
  input  logic [7:0] rev_flags,
  input  logic [20:0] steps,
  input  logic [tdc_pkg::AddrW-1:0] rd_index,
  input  logic [2:0] lvl,
  output logic [11:0] cx,
  output logic [11:0] cy,
  output logic [11:0] cz,
  output logic [20:0] lin
);
  import tdc_pkg::*;

  // two banks ping-pong between levels; bank holds final path after build
  logic [3*CoordW-1:0] mem0 [Depth];
  logic [3*CoordW-1:0] mem1 [Depth];
  logic [3*CoordW-1:0] rd0_r, rd1_r, rdq;
  logic [AddrW-1:0] raddr;
  logic [3*CoordW-1:0] rotp, wdata;
  logic [3*CoordW-1:0] off_r, off_nxt, last_r, last_nxt, min_r, min_nxt;
  logic [3*CoordW-1:0] tgt;
  logic [8:0] r;
  logic rev;
  logic [2:0] s;
  logic [AddrW-1:0] jrd;
  logic [AddrW-1:0] jrev;
  logic [AddrW-1:0] dst_r;
  logic wr_r;
  logic [3*CoordW-1:0] wd_r;
  logic [3*CoordW-1:0] final_r;
  logic [11:0] x_r, y_r, z_r;

  assign r = rot_of(rots, cmd.child);
  assign rev = rev_flags[cmd.child];
  // walk reads one point ahead of the word being written
  assign jrd = (cmd.phase == 2'd2) ? cmd.j + 1'b1 : cmd.j;
  assign jrev = cmd.len_mask - jrd;
  assign s = (cmd.child == 3'd0) ? 3'd0 : steps[3*(cmd.child-3'd1) +: 3];

  always_comb begin
    raddr = rd_index;
    if (cmd.phase != 2'd3) raddr = rev ? jrev : jrd;
  end

  always_ff @(posedge clk) begin
    rd0_r <= mem0[raddr];
    rd1_r <= mem1[raddr];
  end
  assign rdq = cmd.in_bank ? rd1_r : rd0_r;
  assign rotp = rotate(r, rdq);

  // target of the child's first point
  always_comb begin
    tgt = last_r;
    unique case (s)
      3'd1: tgt[0 +: CoordW] = last_r[0 +: CoordW] + 1'b1;
      3'd2: tgt[CoordW +: CoordW] = last_r[CoordW +: CoordW] + 1'b1;
      3'd3: tgt[2*CoordW +: CoordW] = last_r[2*CoordW +: CoordW] + 1'b1;
      3'd7: tgt[0 +: CoordW] = last_r[0 +: CoordW] - 1'b1;
      3'd6: tgt[CoordW +: CoordW] = last_r[CoordW +: CoordW] - 1'b1;
      3'd5: tgt[2*CoordW +: CoordW] = last_r[2*CoordW +: CoordW] - 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    off_nxt = off_r;
    if (cmd.phase == 2'd1) begin
      for (int k = 0; k < 3; k++)
        off_nxt[CoordW*k +: CoordW] = (cmd.child == 3'd0) ? '0 :
          coord_t'(tgt[CoordW*k +: CoordW] - rotp[CoordW*k +: CoordW]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++)
      wdata[CoordW*k +: CoordW] = rotp[CoordW*k +: CoordW] + off_r[CoordW*k +: CoordW];
  end

  always_comb begin
    last_nxt = last_r;
    min_nxt = min_r;
    if (cmd.seed) begin
      last_nxt = '0;
      min_nxt = '0;
    end else if (cmd.phase == 2'd2) begin
      if (cmd.last_j) last_nxt = wdata;
      for (int k = 0; k < 3; k++)
        if (cmd.first_j && cmd.child == 3'd0 ||
            $signed(wdata[CoordW*k +: CoordW]) < $signed(min_r[CoordW*k +: CoordW]))
          min_nxt[CoordW*k +: CoordW] = wdata[CoordW*k +: CoordW];
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    last_r <= last_nxt;
    min_r <= min_nxt;
    wr_r <= cmd.phase == 2'd2 || cmd.seed;
    dst_r <= cmd.seed ? '0 : AddrW'(({3'b0, cmd.child} * (cmd.len_mask + 1'b1)) + cmd.j);
    wd_r <= cmd.seed ? '0 : wdata;
    if (wr_r) begin
      if (cmd.in_bank) mem0[dst_r] <= wd_r;
      else mem1[dst_r] <= wd_r;
    end
    final_r <= min_r;
  end

  // read path: subtract minimum, then form linear index by shifts
  always_ff @(posedge clk) begin
    x_r <= 12'(rdq[0 +: CoordW] - final_r[0 +: CoordW]);
    y_r <= 12'(rdq[CoordW +: CoordW] - final_r[CoordW +: CoordW]);
    z_r <= 12'(rdq[2*CoordW +: CoordW] - final_r[2*CoordW +: CoordW]);
  end
  assign cx = x_r;
  assign cy = y_r;
  assign cz = z_r;
  assign lin = 21'(({9'b0, z_r} << (2 * lvl)) + ({9'b0, y_r} << lvl) + {9'b0, x_r});
endmodule

[src/tdc_ctrl.sv]
// Build/read sequencer of the curve generator.
module tdc_ctrl (
  input  logic clk,
  input  logic rst_n,
  tdc_in_if.sink in_ch,
  tdc_out_if.source out_ch,
  input  logic [71:0] rots,
  input  logic [11:0] dp_x,
  input  logic [11:0] dp_y,
  input  logic [11:0] dp_z,
  input  logic [20:0] dp_lin,
  output tdc_pkg::dp_cmd_t cmd,
  output logic [tdc_pkg::AddrW-1:0] rd_index,
  output logic [2:0] lvl,
  output logic busy
);
  import tdc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_OFF = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_RD = 3'd4;
  localparam logic [2:0] S_RD2 = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_RD3 = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] goal_r, goal_nxt, lvl_r, lvl_nxt, cur_r, cur_nxt, child_r, child_nxt;
  logic [AddrW-1:0] j_r, j_nxt, mask_r, mask_nxt, idx_r, idx_nxt;
  logic bank_r, bank_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic ov_r, ov_nxt;
  logic [1:0] st_r, st_nxt;
  logic [11:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [20:0] lin_r, lin_nxt;
  logic allok;
  logic accept;

  always_comb begin
    allok = 1'b1;
    for (int c = 0; c < 8; c++) allok &= rot_ok(rot_of(rots, 3'(c)));
  end

  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;
  assign accept = in_ch.valid && in_ch.ready;
  assign busy = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r; goal_nxt = goal_r; lvl_nxt = lvl_r; cur_nxt = cur_r;
    child_nxt = child_r; j_nxt = j_r; mask_nxt = mask_r; idx_nxt = idx_r;
    bank_nxt = bank_r; cnt_nxt = cnt_r; ov_nxt = ov_r; st_nxt = st_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; lin_nxt = lin_r;
    cmd = '0;
    cmd.phase = 2'd3;
    cmd.child = child_r; cmd.j = j_r; cmd.len_mask = mask_r;
    cmd.in_bank = bank_r;
    cmd.last_j = j_r == mask_r;
    cmd.first_j = j_r == '0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_nxt = '0; y_nxt = '0; z_nxt = '0; lin_nxt = '0;
          if (in_ch.op == OP_READ) begin
            idx_nxt = AddrW'(in_ch.index);
            if ({1'b0, in_ch.index} >= cnt_r) begin
              st_nxt = ST_INDEX; ov_nxt = 1'b1;
            end else begin
              st_nxt = ST_OK; state_nxt = S_RD;
            end
          end else if (in_ch.level > 3'(MaxLevel)) begin
            st_nxt = ST_LEVEL; ov_nxt = 1'b1;
          end else if (in_ch.level != 3'd0 && !allok) begin
            st_nxt = ST_ROT; ov_nxt = 1'b1;
          end else begin
            st_nxt = ST_OK;
            cmd.seed = 1'b1;
            bank_nxt = 1'b1;  // seed lands in bank 0
            goal_nxt = in_ch.level; cur_nxt = '0; child_nxt = '0;
            j_nxt = '0; mask_nxt = '0;
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // wait for the last write, then start next level or finish
        bank_nxt = ~bank_r;
        cmd.in_bank = bank_r;
        if (cur_r == goal_r) begin
          cnt_nxt = CntW'(1) << (3 * cur_r);
          lvl_nxt = goal_r;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else state_nxt = S_FIRST;
      end
      S_FIRST: begin
        cmd.phase = 2'd0; cmd.j = '0;
        state_nxt = S_OFF;
      end
      S_OFF: begin
        cmd.phase = 2'd1; cmd.j = '0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.phase = 2'd2;
        if (j_r == mask_r) begin
          j_nxt = '0;
          if (child_r == 3'd7) begin
            child_nxt = '0;
            cur_nxt = cur_r + 3'd1;
            mask_nxt = AddrW'({mask_r, 3'b111});
            state_nxt = S_DRAIN;
          end else begin
            child_nxt = child_r + 3'd1;
            state_nxt = S_FIRST;
          end
        end else j_nxt = j_r + 1'b1;
      end
      S_RD: begin
        state_nxt = S_RD2;
      end
      S_RD2: begin
        state_nxt = S_RD3;
      end
      S_RD3: begin
        x_nxt = dp_x; y_nxt = dp_y; z_nxt = dp_z; lin_nxt = dp_lin;
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; lvl_r <= '0; ov_r <= 1'b0; bank_r <= 1'b0;
      cur_r <= '0; child_r <= '0; j_r <= '0; mask_r <= '0; goal_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; lvl_r <= lvl_nxt; ov_r <= ov_nxt;
      bank_r <= bank_nxt; cur_r <= cur_nxt; child_r <= child_nxt; j_r <= j_nxt;
      mask_r <= mask_nxt; goal_r <= goal_nxt;
    end
  end
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; st_r <= st_nxt; x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    lin_r <= lin_nxt;
  end

  assign rd_index = idx_r;
  assign lvl = lvl_r;
  assign out_ch.valid = ov_r;
  assign out_ch.status = st_r;
  assign out_ch.point_count = cnt_r;
  assign out_ch.coord_x = x_r;
  assign out_ch.coord_y = y_r;
  assign out_ch.coord_z = z_r;
  assign out_ch.linear_index = lin_r;
endmodule

[src/table_driven_3d_curve_generator_unit.sv]
// Read: the word passes S_RD, S_RD2 and S_RD3 before the result is valid;
// one read in flight. Build at level L: each level below L runs S_FIRST,
// S_OFF, S_WALK per child, then S_DRAIN; the walk writes one point a cycle.
// Errors answer in the cycle after accept. Result register holds until taken.
// rst_n clears control, config tables to defaults, built count to zero.
`include "table_driven_3d_curve_generator_unit_defines.svh"
module table_driven_3d_curve_generator_unit (
  input logic clk,
  input logic rst_n,
  tdc_in_if.sink in_ch,
  tdc_out_if.source out_ch,
  tdc_cfg_if.sink cfg_ch
);
  import tdc_pkg::*;

  logic [20:0] steps_r;
  logic [71:0] rots_r;
  logic [7:0] rev_r;
  dp_cmd_t cmd;
  logic [AddrW-1:0] rd_index;
  logic [2:0] lvl;
  logic busy;
  logic [11:0] dx, dy, dz;
  logic [20:0] dlin;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
      rots_r <= {36'd28106400465, 36'd28106400465};
      rev_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_STEP: steps_r <= cfg_ch.data[20:0];
        REG_ROT_LO: rots_r[35:0] <= cfg_ch.data;
        REG_ROT_HI: rots_r[71:36] <= cfg_ch.data;
        REG_REV: rev_r <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  tdc_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .rots(rots_r),
    .dp_x(dx), .dp_y(dy), .dp_z(dz), .dp_lin(dlin),
    .cmd, .rd_index, .lvl, .busy
  );

  tdc_datapath u_dp (
    .clk, .cmd, .rots(rots_r), .rev_flags(rev_r), .steps(steps_r),
    .rd_index, .lvl, .cx(dx), .cy(dy), .cz(dz), .lin(dlin)
  );

  `TDC_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, busy, !in_ch.ready, "input taken while busy")
  `TDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid,
                   "result dropped")
  `TDC_ASSERT_IMPL(a_idle_out, clk, rst_n, out_ch.valid, !busy, "result shown mid-build")
endmodule

[tb/tb_table_driven_3d_curve_generator_unit.sv]
// Testbench for the table-driven 3D curve generator: random builds and reads against a predictor.
`timescale 1ns / 100ps
module tb_table_driven_3d_curve_generator_unit;
  import tdc_pkg::*;

  localparam int WatchdogLimit = 200000;

  typedef struct {
    logic        op;
    logic [2:0]  level;
    logic [11:0] index;
  } cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [12:0] point_count;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [11:0] cz;
    logic [20:0] lin;
  } answer_t;

  logic clk;
  logic rst_n;

  tdc_in_if  in_ch ();
  tdc_out_if out_ch ();
  tdc_cfg_if cfg_ch ();

  table_driven_3d_curve_generator_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // predictor copy of the tables and the path
  logic [20:0] steps_q;
  logic [71:0] rots_q;
  logic [7:0]  rev_q;
  int          px [Depth];
  int          py [Depth];
  int          pz [Depth];
  int          sx [Depth];
  int          sy [Depth];
  int          sz [Depth];
  int          pts_built;
  int          lvl_built;

  cmd_t    cmd_q[$];
  answer_t answers_q[$];
  int      issued;
  int      checked;
  int      errors;
  int      idle_cycles;
  int      send_gap_pct;
  int      recv_stall_pct;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int code_val(input logic [2:0] c);
    return int'($signed(c));
  endfunction

  function automatic logic tables_valid();
    int r, a;
    logic [2:0] seen;
    for (int c = 0; c < 8; c++) begin
      seen = '0;
      for (int k = 0; k < 3; k++) begin
        r = code_val(rots_q[9*c+3*k +: 3]);
        a = r < 0 ? -r : r;
        if (a < 1 || a > 3) return 1'b0;
        seen[a-1] = 1'b1;
      end
      if (seen != 3'b111) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic turn_point(input int c, input int src, output int q[3]);
    int p[3];
    int r, a;
    p[0] = px[src];
    p[1] = py[src];
    p[2] = pz[src];
    for (int k = 0; k < 3; k++) begin
      r = code_val(rots_q[9*c+3*k +: 3]);
      a = (r < 0 ? -r : r) - 1;
      q[a] = r < 0 ? -p[k] : p[k];
    end
  endtask

  task automatic grow_curve(input int lvl);
    int len, s, src, dst;
    int last[3];
    int tgt[3];
    int off[3];
    int q[3];
    int mn[3];
    logic rev;
    len = 1;
    px[0] = 0;
    py[0] = 0;
    pz[0] = 0;
    for (int l = 0; l < lvl; l++) begin
      last = '{0, 0, 0};
      for (int c = 0; c < 8; c++) begin
        rev = rev_q[c];
        off = '{0, 0, 0};
        if (c > 0) begin
          s = code_val(steps_q[3*(c-1) +: 3]);
          tgt = last;
          if (s >= 1 && s <= 3) tgt[s-1] += 1;
          if (s <= -1 && s >= -3) tgt[-s-1] -= 1;
          turn_point(c, rev ? len - 1 : 0, q);
          for (int k = 0; k < 3; k++) off[k] = tgt[k] - q[k];
        end
        for (int j = 0; j < len; j++) begin
          src = rev ? len - 1 - j : j;
          dst = c * len + j;
          turn_point(c, src, q);
          sx[dst] = q[0] + off[0];
          sy[dst] = q[1] + off[1];
          sz[dst] = q[2] + off[2];
          if (j == len - 1) last = '{sx[dst], sy[dst], sz[dst]};
        end
      end
      len *= 8;
      for (int i = 0; i < len; i++) begin
        px[i] = sx[i];
        py[i] = sy[i];
        pz[i] = sz[i];
      end
    end
    mn = '{px[0], py[0], pz[0]};
    for (int i = 1; i < len; i++) begin
      if (px[i] < mn[0]) mn[0] = px[i];
      if (py[i] < mn[1]) mn[1] = py[i];
      if (pz[i] < mn[2]) mn[2] = pz[i];
    end
    for (int i = 0; i < len; i++) begin
      px[i] -= mn[0];
      py[i] -= mn[1];
      pz[i] -= mn[2];
    end
    pts_built = len;
    lvl_built = lvl;
  endtask

  task automatic predict_answer(input cmd_t cmd);
    answer_t a;
    longint dim;
    a = '{ST_OK, 13'd0, 12'd0, 12'd0, 12'd0, 21'd0};
    if (cmd.op == OP_BUILD) begin
      if (cmd.level > MaxLevel) a.status = ST_LEVEL;
      else if (cmd.level >= 1 && !tables_valid()) a.status = ST_ROT;
      else grow_curve(cmd.level);
    end else if (cmd.index >= pts_built) begin
      a.status = ST_INDEX;
    end else begin
      dim = longint'(1) << lvl_built;
      a.cx = px[cmd.index][11:0];
      a.cy = py[cmd.index][11:0];
      a.cz = pz[cmd.index][11:0];
      a.lin = 21'(longint'(pz[cmd.index]) * dim * dim + longint'(py[cmd.index]) * dim
                  + longint'(px[cmd.index]));
    end
    a.point_count = 13'(pts_built);
    answers_q.push_back(a);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    cmd_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= OP_BUILD;
      in_ch.level <= '0;
      in_ch.index <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_answer('{in_ch.op, in_ch.level, in_ch.index});
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          c = cmd_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= c.op;
          in_ch.level <= c.level;
          in_ch.index <= c.index;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answers_q.size() == 0) begin
          report("unexpected word", 32'(out_ch.status), 32'd0);
        end else begin
          w = answers_q.pop_front();
          if (out_ch.status !== w.status) report("status", 32'(out_ch.status), 32'(w.status));
          if (out_ch.point_count !== w.point_count)
            report("point_count", 32'(out_ch.point_count), 32'(w.point_count));
          if (out_ch.coord_x !== w.cx) report("coord_x", 32'(out_ch.coord_x), 32'(w.cx));
          if (out_ch.coord_y !== w.cy) report("coord_y", 32'(out_ch.coord_y), 32'(w.cy));
          if (out_ch.coord_z !== w.cz) report("coord_z", 32'(out_ch.coord_z), 32'(w.cz));
          if (out_ch.linear_index !== w.lin)
            report("linear_index", 32'(out_ch.linear_index), 32'(w.lin));
        end
        checked++;
      end
      out_ch.ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // watchdog: count cycles in which no word moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_cmd(input logic op, input logic [2:0] lvl, input logic [11:0] idx);
    cmd_q.push_back('{op, lvl, idx});
    issued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [35:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_STEP:   steps_q = data[20:0];
      REG_ROT_LO: rots_q[35:0] = data;
      REG_ROT_HI: rots_q[71:36] = data;
      default:    rev_q = data[7:0];
    endcase
  endtask

  function automatic logic [35:0] good_rots();
    logic [35:0] w;
    int perm[3];
    int t, j;
    for (int c = 0; c < 4; c++) begin
      perm = '{1, 2, 3};
      for (int k = 2; k > 0; k--) begin
        j = $urandom_range(k);
        t = perm[k];
        perm[k] = perm[j];
        perm[j] = t;
      end
      for (int k = 0; k < 3; k++)
        w[9*c+3*k +: 3] = $urandom_range(1) ? 3'(perm[k]) : 3'(8 - perm[k]);
    end
    return w;
  endfunction

  task automatic drain();
    while (checked != issued) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    int lvl, span;
    logic [35:0] lo;
    rst_n = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_STEP;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_BUILD;
    in_ch.level = '0;
    in_ch.index = '0;
    out_ch.ready = 1'b0;
    steps_q = '0;
    rots_q = {2{36'd28106400465}};
    rev_q = '0;
    pts_built = 0;
    lvl_built = 0;
    issued = 0;
    checked = 0;
    errors = 0;
    idle_cycles = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reads before any build, level errors, default tables
    push_cmd(OP_READ, 3'd0, 12'd0);
    push_cmd(OP_BUILD, 3'd7, 12'hFFF);
    push_cmd(OP_BUILD, 3'd5, 12'd0);
    push_cmd(OP_BUILD, 3'd0, 12'd0);
    push_cmd(OP_READ, 3'd7, 12'd0);
    push_cmd(OP_READ, 3'd0, 12'd1);
    push_cmd(OP_BUILD, 3'd1, 12'd0);
    for (int i = 0; i < 8; i++) push_cmd(OP_READ, 3'd0, 12'(i));
    push_cmd(OP_READ, 3'd0, 12'hFFF);
    drain();

    // directed: broken rotation table, then extremes of the tables
    write_reg(REG_ROT_LO, 36'd0);
    push_cmd(OP_BUILD, 3'd1, 12'd0);
    push_cmd(OP_BUILD, 3'd0, 12'd0);
    push_cmd(OP_READ, 3'd0, 12'd0);
    drain();
    write_reg(REG_ROT_LO, 36'hFFFFFFFFF);
    write_reg(REG_ROT_HI, good_rots());
    push_cmd(OP_BUILD, 3'd2, 12'd0);
    drain();
    write_reg(REG_ROT_LO, good_rots());
    write_reg(REG_STEP, 36'h1FFFFF);
    write_reg(REG_REV, 36'hFF);
    push_cmd(OP_BUILD, 3'd4, 12'd0);
    push_cmd(OP_READ, 3'd0, 12'hFFF);
    push_cmd(OP_READ, 3'd0, 12'h000);
    push_cmd(OP_READ, 3'd0, 12'h555);
    drain();

    // random phases, cycling through the idling modes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
        default: begin send_gap_pct = 32; recv_stall_pct = 32; end
      endcase
      write_reg(REG_STEP, 36'($urandom_range(21'h1FFFFF)));
      lo = good_rots();
      // now and then break one code of the table
      if ($urandom_range(5) == 0) lo[3*$urandom_range(11) +: 3] = 3'($urandom_range(1) * 4);
      write_reg(REG_ROT_LO, lo);
      write_reg(REG_ROT_HI, good_rots());
      write_reg(REG_REV, 36'($urandom_range(255)));
      lvl = (ph == 3 || ph == 6) ? 4 : $urandom_range(1, 3);
      span = 1 << (3 * lvl);
      push_cmd(OP_BUILD, 3'(lvl), 12'($urandom));
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(19))
          0: push_cmd(OP_BUILD, 3'($urandom_range(5, 7)), 12'($urandom));
          1: push_cmd(OP_READ, 3'($urandom), 12'($urandom));
          2: push_cmd(OP_READ, 3'($urandom), 12'(span - 1));
          default: push_cmd(OP_READ, 3'($urandom), 12'($urandom_range(span - 1)));
        endcase
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+src
src/tdc_pkg.sv
src/tdc_if.sv
src/tdc_datapath.sv
src/tdc_ctrl.sv
src/table_driven_3d_curve_generator_unit.sv
tb/tb_table_driven_3d_curve_generator_unit.sv
